[rtl/afq_pkg.sv]
// Shared types, constants and helper functions for the alphanumeric
// frequency ranking block. No dependencies; imported by every module but afq_ram.

package afq_pkg;

   localparam int SYMBOL_COUNT = 36;
   localparam int COUNT_BITS = 32;

   localparam int SLOT_W = $clog2(SYMBOL_COUNT);
   localparam int SYM_CNT_W = $clog2(SYMBOL_COUNT + 1);
   localparam int ORDER_W = 6;
   localparam int ENTRY_W = COUNT_BITS + ORDER_W;
   localparam int PCT_W = 14;
   localparam int NUM_W = COUNT_BITS + PCT_W;
   localparam int DIV_CNT_W = $clog2(PCT_W);
   localparam int OUT_COUNT_W = 32;
   localparam int SYMBOL_W = 7;
   localparam int BYTE_W = 8;
   localparam int CSR_W = 6;

   localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(10000);
   localparam logic [CSR_W-1:0] REPORT_LENGTH_RESET = CSR_W'(10);
   localparam logic [SYM_CNT_W-1:0] SYMBOL_MAX = SYM_CNT_W'(SYMBOL_COUNT);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SYMBOL_COUNT - 1);
   localparam logic [SLOT_W-1:0] DIGIT_SLOTS = SLOT_W'(10);

   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'd57;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

   typedef struct packed {
      logic                rd_byte;
      logic                upd;
      logic                scan_rd;
      logic                scan_start;
      logic [SLOT_W-1:0]   scan_addr;
      logic                mul;
      logic                div_step;
      logic                emit;
      logic                emit_empty;
      logic                last;
      logic                clear;
   } cmd_type;

   typedef struct packed {
      logic                 alnum;
      logic                 total_zero;
      logic                 out_free;
      logic [SYM_CNT_W-1:0] distinct;
   } status_type;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         r = b + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] f;
      f = fold_case(b);
      return (b >= CHAR_ZERO && b <= CHAR_NINE) || (f >= CHAR_LOWER_A && f <= CHAR_LOWER_Z);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] f;
      logic [SLOT_W-1:0] r;
      f = fold_case(b);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         r = SLOT_W'(b - CHAR_ZERO);
      end else begin
         r = SLOT_W'(f - CHAR_LOWER_A) + DIGIT_SLOTS;
      end
      return r;
   endfunction

   function automatic logic [SYMBOL_W-1:0] code_of(input logic [SLOT_W-1:0] s);
      logic [SYMBOL_W-1:0] r;
      if (s < DIGIT_SLOTS) begin
         r = SYMBOL_W'(CHAR_ZERO) + SYMBOL_W'(s);
      end else begin
         r = SYMBOL_W'(CHAR_LOWER_A) + SYMBOL_W'(s - DIGIT_SLOTS);
      end
      return r;
   endfunction

   function automatic logic [OUT_COUNT_W-1:0] count_out(input logic [COUNT_BITS-1:0] c);
      logic [OUT_COUNT_W-1:0] r;
      r = OUT_COUNT_W'(c);
      if (COUNT_BITS > OUT_COUNT_W && (c >> OUT_COUNT_W) != '0) begin
         r = '1;
      end
      return r;
   endfunction

endpackage

[rtl/afq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module afq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/afq_ctrl.sv]
// Controller state machine for the frequency ranking block: sequences byte
// updates, ranking scans, percentage division and result transfers. Uses afq_pkg.

module afq_ctrl
   import afq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_end_of_set,
   input  logic             csr_write_en,
   input  logic [CSR_W-1:0] csr_write_data,
   input  status_type       st,
   output cmd_type          cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_UPD, ST_EMPTY, ST_SCAN, ST_SEL, ST_MUL, ST_DIV, ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     report_length_ff;
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [SYM_CNT_W-1:0] rank_ff, rank_in;
   logic [SYM_CNT_W-1:0] want_ff, want_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [SYM_CNT_W-1:0] want_cfg;
   logic                 accept;
   logic                 last_rank;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign last_rank = (rank_ff + SYM_CNT_W'(1)) == want_ff;

   always_comb begin
      if (report_length_ff == '0) begin
         want_cfg = SYM_CNT_W'(1);
      end else if (SYM_CNT_W'(report_length_ff) > SYMBOL_MAX) begin
         want_cfg = SYMBOL_MAX;
      end else begin
         want_cfg = SYM_CNT_W'(report_length_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      scan_idx_in = scan_idx_ff;
      rank_in = rank_ff;
      want_in = want_ff;
      div_cnt_in = div_cnt_ff;
      cmd = '0;
      cmd.scan_addr = scan_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_end_of_set) begin
                  if (st.total_zero) begin
                     state_in = ST_EMPTY;
                  end else begin
                     want_in = (want_cfg > st.distinct) ? st.distinct : want_cfg;
                     rank_in = '0;
                     scan_idx_in = '0;
                     state_in = ST_SCAN;
                  end
               end else if (st.alnum) begin
                  cmd.rd_byte = 1'b1;
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EMPTY: begin
            if (st.out_free) begin
               cmd.emit_empty = 1'b1;
               cmd.clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.scan_start = (scan_idx_ff == '0);
            scan_idx_in = scan_idx_ff + SLOT_W'(1);
            if (scan_idx_ff == SLOT_LAST) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            div_cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(PCT_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = last_rank;
               if (last_rank) begin
                  cmd.clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  rank_in = rank_ff + SYM_CNT_W'(1);
                  scan_idx_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         report_length_ff <= REPORT_LENGTH_RESET;
         scan_idx_ff <= '0;
         rank_ff <= '0;
         want_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         scan_idx_ff <= scan_idx_in;
         rank_ff <= rank_in;
         want_ff <= want_in;
         div_cnt_ff <= div_cnt_in;
         if (csr_write_en) begin
            report_length_ff <= csr_write_data;
         end
      end
   end

endmodule

[rtl/afq_dp.sv]
// Datapath for the frequency ranking block: count RAM with valid flags,
// totals, best-candidate search, multiply, restoring divider and result
// register. Uses afq_pkg and afq_ram.

module afq_dp
   import afq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             st,
   input  logic [BYTE_W-1:0]      req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SYMBOL_W-1:0]    rsp_symbol,
   output logic [OUT_COUNT_W-1:0] rsp_symbol_count,
   output logic [PCT_W-1:0]       rsp_percent_hundredths,
   output logic                   rsp_no_data,
   output logic                   rsp_last_result
);

   logic [SYMBOL_COUNT-1:0] valid_ff;
   logic [SYMBOL_COUNT-1:0] marks_ff;
   logic [SYM_CNT_W-1:0]    distinct_ff;
   logic [COUNT_BITS-1:0]   total_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic                    cmp_pend_ff;
   logic [SLOT_W-1:0]       idx_d_ff;
   logic                    best_found_ff;
   logic [SLOT_W-1:0]       best_idx_ff;
   logic [COUNT_BITS-1:0]   best_cnt_ff;
   logic [ORDER_W-1:0]      best_ord_ff;
   logic [COUNT_BITS-1:0]   rem_ff;
   logic [PCT_W-1:0]        low_ff;
   logic [PCT_W-1:0]        quo_ff;
   logic                    rsp_valid_ff;
   logic [SYMBOL_W-1:0]     symbol_ff;
   logic [OUT_COUNT_W-1:0]  count_ff;
   logic [PCT_W-1:0]        pct_ff;
   logic                    no_data_ff;
   logic                    last_ff;

   logic [SLOT_W-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic [COUNT_BITS-1:0]   rd_cnt;
   logic [ORDER_W-1:0]      rd_ord;
   logic                    upd_valid;
   logic [COUNT_BITS-1:0]   old_cnt;
   logic [COUNT_BITS-1:0]   new_cnt;
   logic [ORDER_W-1:0]      new_ord;
   logic                    cand;
   logic                    better;
   logic [NUM_W-1:0]        product;
   logic [COUNT_BITS:0]     rem_shift;
   logic                    rem_ge;

   assign ram_rd_addr = cmd.rd_byte ? slot_of(req_data_byte) : cmd.scan_addr;
   assign rd_cnt = ram_rd_data[COUNT_BITS-1:0];
   assign rd_ord = ram_rd_data[ENTRY_W-1:COUNT_BITS];

   assign upd_valid = valid_ff[slot_ff];
   assign old_cnt = upd_valid ? rd_cnt : '0;
   assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);
   assign new_ord = upd_valid ? rd_ord : ORDER_W'(distinct_ff);
   assign ram_wr_data = {new_ord, new_cnt};

   afq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SYMBOL_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cmd.upd),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cand = cmp_pend_ff && valid_ff[idx_d_ff] && !marks_ff[idx_d_ff];
   assign better = !best_found_ff || (rd_cnt > best_cnt_ff) ||
                   ((rd_cnt == best_cnt_ff) && (rd_ord < best_ord_ff));

   assign product = NUM_W'(best_cnt_ff) * NUM_W'(PCT_SCALE);
   assign rem_shift = {rem_ff, low_ff[PCT_W-1]};
   assign rem_ge = rem_shift >= {1'b0, total_ff};

   assign st.alnum = is_alnum(req_data_byte);
   assign st.total_zero = (total_ff == '0);
   assign st.out_free = !rsp_valid_ff || !rsp_stall;
   assign st.distinct = distinct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         marks_ff <= '0;
         distinct_ff <= '0;
         total_ff <= '0;
         cmp_pend_ff <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_pend_ff <= cmd.scan_rd;
         if (cmd.clear) begin
            valid_ff <= '0;
            marks_ff <= '0;
            distinct_ff <= '0;
            total_ff <= '0;
         end else begin
            if (cmd.upd) begin
               valid_ff[slot_ff] <= 1'b1;
               if (!upd_valid && distinct_ff < SYMBOL_MAX) begin
                  distinct_ff <= distinct_ff + SYM_CNT_W'(1);
               end
               if (total_ff != '1) begin
                  total_ff <= total_ff + COUNT_BITS'(1);
               end
            end
            if (cmd.emit) begin
               marks_ff[best_idx_ff] <= 1'b1;
            end
         end
         if (cmd.scan_start) begin
            best_found_ff <= 1'b0;
         end else if (cand && better) begin
            best_found_ff <= 1'b1;
         end
         if (cmd.emit || cmd.emit_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_byte) begin
         slot_ff <= ram_rd_addr;
      end
      idx_d_ff <= cmd.scan_addr;
      if (!cmd.scan_start && cand && better) begin
         best_idx_ff <= idx_d_ff;
         best_cnt_ff <= rd_cnt;
         best_ord_ff <= rd_ord;
      end
      if (cmd.mul) begin
         rem_ff <= product[NUM_W-1:PCT_W];
         low_ff <= product[PCT_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? COUNT_BITS'(rem_shift - {1'b0, total_ff})
                          : rem_shift[COUNT_BITS-1:0];
         low_ff <= {low_ff[PCT_W-2:0], 1'b0};
         quo_ff <= {quo_ff[PCT_W-2:0], rem_ge};
      end
      if (cmd.emit) begin
         symbol_ff <= code_of(best_idx_ff);
         count_ff <= count_out(best_cnt_ff);
         pct_ff <= (quo_ff > PCT_SCALE) ? PCT_SCALE : quo_ff;
         no_data_ff <= 1'b0;
         last_ff <= cmd.last;
      end else if (cmd.emit_empty) begin
         symbol_ff <= '0;
         count_ff <= '0;
         pct_ff <= '0;
         no_data_ff <= 1'b1;
         last_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_symbol_count = count_ff;
   assign rsp_percent_hundredths = pct_ff;
   assign rsp_no_data = no_data_ff;
   assign rsp_last_result = last_ff;

endmodule

[rtl/alnum_frequency_top_n.sv]
// Top level of the alphanumeric frequency ranking block: joins the controller
// and the datapath. Uses afq_pkg, afq_ctrl and afq_dp.
//
//   Channel   Direction  Handshake               Payload
//   req       in         req_valid / req_stall   req_data_byte, req_end_of_set
//   rsp       out        rsp_valid / rsp_stall   symbol, count, percent, flags
//   csr       in         csr_write_en            csr_write_data (report length)
//
// A letter or digit stalls the request while its count RAM entry is read and
// written back; any other byte is taken without a stall. A report gives each
// result through a scan of the count RAM, one select, one multiply, 14 divide
// steps and one transfer. An empty set answers with one result.
// Reset is synchronous; the counters clear at once through per-entry valid flags.
// A stalled result holds in the output register; the report waits behind it.

module alnum_frequency_top_n
   import afq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_end_of_set,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SYMBOL_W-1:0]    rsp_symbol,
   output logic [OUT_COUNT_W-1:0] rsp_symbol_count,
   output logic [PCT_W-1:0]       rsp_percent_hundredths,
   output logic                   rsp_no_data,
   output logic                   rsp_last_result,
   input  logic                   csr_write_en,
   input  logic [CSR_W-1:0]       csr_write_data
);

   cmd_type    cmd;
   status_type st;

   afq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_end_of_set (req_end_of_set),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .st             (st),
      .cmd            (cmd)
   );

   afq_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .st                     (st),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_symbol             (rsp_symbol),
      .rsp_symbol_count       (rsp_symbol_count),
      .rsp_percent_hundredths (rsp_percent_hundredths),
      .rsp_no_data            (rsp_no_data),
      .rsp_last_result        (rsp_last_result)
   );

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_empty) |-> st.out_free)
      else $error("Result loaded while the output register still holds a stalled transfer.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_data |-> rsp_last_result)
      else $error("Empty-set result is not marked as the last one.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_percent_hundredths <= PCT_SCALE)
      else $error("Percentage exceeds the full scale.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.upd |-> !cmd.scan_rd && !cmd.emit && !cmd.clear)
      else $error("Count update overlaps a report step.");

endmodule

[tb/alnum_frequency_top_n_test.sv]
// Testbench for the alphanumeric frequency ranking block: directed and random
// byte sets, checked result by result against an in-bench ranking predictor.
// Depends on afq_pkg and alnum_frequency_top_n from the rtl folder.

module alnum_frequency_top_n_test
   import afq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 330;
   localparam int IDLE_PERCENT = 18;
   localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;

   typedef struct {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_set;
   } byte_item_type;

   typedef struct {
      logic [SYMBOL_W-1:0]    symbol;
      logic [OUT_COUNT_W-1:0] symbol_count;
      logic [PCT_W-1:0]       percent;
      logic                   no_data;
      logic                   last_result;
   } rank_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_end_of_set = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SYMBOL_W-1:0]    rsp_symbol;
   logic [OUT_COUNT_W-1:0] rsp_symbol_count;
   logic [PCT_W-1:0]       rsp_percent_hundredths;
   logic                   rsp_no_data;
   logic                   rsp_last_result;
   logic                   csr_write_en = 1'b0;
   logic [CSR_W-1:0]       csr_write_data = '0;

   byte_item_type pending_bytes[$];
   rank_type      expected_ranks[$];
   byte_item_type next_item;
   logic       req_fire = 1'b0;
   bit         no_idle = 1'b0;
   bit         hold_request = 1'b0;
   bit         hold_used = 1'b0;
   int         hold_left = 0;
   int         error_count = 0;
   int         quiet_cycles = 0;
   int         items_queued = 0;

   logic [63:0]      tally[SYMBOL_COUNT];
   logic [ORDER_W-1:0] first_seen[SYMBOL_COUNT];
   bit               ranked[SYMBOL_COUNT];
   int               distinct = 0;
   logic [63:0]      grand_total = '0;
   logic [CSR_W-1:0] top_n = REPORT_LENGTH_RESET;

   alnum_frequency_top_n u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_end_of_set         (req_end_of_set),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_symbol             (rsp_symbol),
      .rsp_symbol_count       (rsp_symbol_count),
      .rsp_percent_hundredths (rsp_percent_hundredths),
      .rsp_no_data            (rsp_no_data),
      .rsp_last_result        (rsp_last_result),
      .csr_write_en           (csr_write_en),
      .csr_write_data         (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int slot_for(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] f;
      f = b;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         return int'(b - CHAR_ZERO);
      end
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         f = b + CASE_OFFSET;
      end
      if (f >= CHAR_LOWER_A && f <= CHAR_LOWER_Z) begin
         return int'(f - CHAR_LOWER_A) + int'(DIGIT_SLOTS);
      end
      return -1;
   endfunction

   function automatic logic [BYTE_W-1:0] byte_of_slot(input int s, input bit upper);
      if (s < int'(DIGIT_SLOTS)) begin
         return CHAR_ZERO + BYTE_W'(s);
      end
      if (upper) begin
         return CHAR_UPPER_A + BYTE_W'(s - int'(DIGIT_SLOTS));
      end
      return CHAR_LOWER_A + BYTE_W'(s - int'(DIGIT_SLOTS));
   endfunction

   function automatic void clear_tally();
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         tally[i] = '0;
         first_seen[i] = '0;
         ranked[i] = 1'b0;
      end
      distinct = 0;
      grand_total = '0;
   endfunction

   function automatic void rank_item(input logic [BYTE_W-1:0] b, input logic eos);
      int          s;
      int          want;
      int          best;
      rank_type    r;
      logic [63:0] pct;
      if (!eos) begin
         s = slot_for(b);
         if (s >= 0) begin
            if (tally[s] == 0) begin
               first_seen[s] = ORDER_W'(distinct);
               if (distinct < SYMBOL_COUNT) begin
                  distinct++;
               end
            end
            if (tally[s] < COUNT_LIMIT) begin
               tally[s]++;
            end
            if (grand_total < COUNT_LIMIT) begin
               grand_total++;
            end
         end
      end else if (grand_total == 0) begin
         r.symbol = '0;
         r.symbol_count = '0;
         r.percent = '0;
         r.no_data = 1'b1;
         r.last_result = 1'b1;
         expected_ranks.push_back(r);
         clear_tally();
      end else begin
         want = int'(top_n);
         if (want == 0) begin
            want = 1;
         end
         if (want > SYMBOL_COUNT) begin
            want = SYMBOL_COUNT;
         end
         if (want > distinct) begin
            want = distinct;
         end
         for (int k = 0; k < want; k++) begin
            best = -1;
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
               if (tally[i] != 0 && !ranked[i]) begin
                  if (best < 0 || tally[i] > tally[best] ||
                      (tally[i] == tally[best] && first_seen[i] < first_seen[best])) begin
                     best = i;
                  end
               end
            end
            ranked[best] = 1'b1;
            pct = (tally[best] * 64'd10000) / grand_total;
            if (pct > 64'd10000) begin
               pct = 64'd10000;
            end
            r.symbol = SYMBOL_W'(byte_of_slot(best, 1'b0));
            r.symbol_count = (tally[best] > 64'hFFFF_FFFF) ? '1 : OUT_COUNT_W'(tally[best]);
            r.percent = PCT_W'(pct);
            r.no_data = 1'b0;
            r.last_result = (k == want - 1);
            expected_ranks.push_back(r);
         end
         clear_tally();
      end
   endfunction

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         rank_item(req_data_byte, req_end_of_set);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_bytes.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            next_item = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_item.data_byte;
            req_end_of_set <= next_item.end_of_set;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_used && rsp_valid) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      rank_type want_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ranks.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected result: sym %0d cnt %0d pct %0d nd %0b last %0b",
                        rsp_symbol, rsp_symbol_count, rsp_percent_hundredths,
                        rsp_no_data, rsp_last_result);
            end
         end else begin
            want_r = expected_ranks.pop_front();
            if (rsp_symbol !== want_r.symbol || rsp_symbol_count !== want_r.symbol_count ||
                rsp_percent_hundredths !== want_r.percent ||
                rsp_no_data !== want_r.no_data || rsp_last_result !== want_r.last_result) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: expected sym %0d cnt %0d pct %0d nd %0b last %0b",
                           want_r.symbol, want_r.symbol_count, want_r.percent,
                           want_r.no_data, want_r.last_result);
                  $display("          actual   sym %0d cnt %0d pct %0d nd %0b last %0b",
                           rsp_symbol, rsp_symbol_count, rsp_percent_hundredths,
                           rsp_no_data, rsp_last_result);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("alnum_frequency_top_n test failed");
         $finish;
      end
   end

   task automatic push_item(input logic [BYTE_W-1:0] b, input logic eos);
      byte_item_type it;
      it.data_byte = b;
      it.end_of_set = eos;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   task automatic push_random_set();
      int kind;
      int len;
      int span;
      int base;
      int s;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         len = 0;
      end else if (kind == 1) begin
         len = $urandom_range(40, 70);
      end else begin
         len = $urandom_range(1, 16);
      end
      span = $urandom_range(1, SYMBOL_COUNT);
      base = $urandom_range(0, SYMBOL_COUNT - 1);
      repeat (len) begin
         if ($urandom_range(0, 4) == 0) begin
            push_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
         end else begin
            s = (base + $urandom_range(0, span - 1)) % SYMBOL_COUNT;
            push_item(byte_of_slot(s, 1'($urandom_range(0, 1))), 1'b0);
         end
      end
      push_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic push_full_set();
      int off;
      off = $urandom_range(0, SYMBOL_COUNT - 1);
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         push_item(byte_of_slot((i * 7 + off) % SYMBOL_COUNT, 1'($urandom_range(0, 1))),
                   1'b0);
      end
      repeat ($urandom_range(0, 30)) begin
         push_item(byte_of_slot($urandom_range(0, SYMBOL_COUNT - 1), 1'b0), 1'b0);
      end
      push_item(8'h00, 1'b1);
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || expected_ranks.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [CSR_W-1:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      top_n = v;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0] lengths[6];
      int phase;
      lengths = '{6'd36, 6'd63, 6'd1, 6'd37, 6'd2, 6'd10};
      clear_tally();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(8'h00, 1'b1);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(CHAR_UPPER_A, 1'b0);
      push_item(CHAR_LOWER_Z, 1'b0);
      push_item(CHAR_UPPER_Z, 1'b0);
      push_item(CHAR_LOWER_A, 1'b0);
      push_item(CHAR_NINE, 1'b0);
      push_item(CHAR_UPPER_A - 8'd1, 1'b0);
      push_item(CHAR_UPPER_Z + 8'd1, 1'b0);
      push_item(CHAR_LOWER_A - 8'd1, 1'b0);
      push_item(CHAR_LOWER_Z + 8'd1, 1'b0);
      push_item(CHAR_ZERO - 8'd1, 1'b0);
      push_item(CHAR_NINE + 8'd1, 1'b0);
      push_item(CHAR_LOWER_A + 8'd1, 1'b0);
      push_item(CHAR_ZERO, 1'b0);
      push_item(8'hFF, 1'b1);
      drain();
      write_length(6'd0);
      push_item(CHAR_LOWER_Z - 8'd2, 1'b0);
      push_item(CHAR_UPPER_Z - 8'd1, 1'b0);
      push_item(CHAR_LOWER_Z - 8'd1, 1'b0);
      push_item(8'h55, 1'b1);
      drain();

      items_queued = 0;
      phase = 0;
      while (items_queued < RANDOM_ITEMS) begin
         if (phase < 6) begin
            write_length(lengths[phase]);
         end else begin
            write_length(CSR_W'($urandom_range(0, 63)));
         end
         hold_request = (phase == 0);
         no_idle = (phase == 2);
         if (phase == 0) begin
            push_item(CHAR_LOWER_A, 1'b0);
            push_item(CHAR_NINE, 1'b0);
            push_item(8'h00, 1'b1);
            push_full_set();
         end
         if (phase == 1) begin
            push_full_set();
         end
         repeat ($urandom_range(3, 6)) push_random_set();
         drain();
         phase++;
      end
      no_idle = 1'b0;
      drain();

      if (error_count == 0 && expected_ranks.size() == 0) begin
         $display("alnum_frequency_top_n test passed");
      end else begin
         $display("alnum_frequency_top_n test failed");
      end
      $finish;
   end

endmodule
